>>> rtl/fpa_pkg.sv
// Shared constants, command codes and pipeline types for the Q24.8 fixed-point ALU.
package fpa_pkg;

	// Word format
	localparam int FRAC_BITS = 8;
	localparam int W         = 32;

	// Command codes
	localparam logic [2:0] CMD_ADD = 3'd0;
	localparam logic [2:0] CMD_SUB = 3'd1;
	localparam logic [2:0] CMD_MUL = 3'd2;
	localparam logic [2:0] CMD_DIV = 3'd3;
	localparam logic [2:0] CMD_MIN = 3'd4;
	localparam logic [2:0] CMD_MAX = 3'd5;
	localparam logic [2:0] CMD_INC = 3'd6;

	// Saturation limits
	localparam logic [W-1:0] WORD_MAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] WORD_MIN = {1'b1, {(W-1){1'b0}}};

	// Three front stages, one divider cell per quotient bit, one output stage
	localparam int LATENCY = 3 + W + 1;

	// Per-word side information carried alongside the divider datapath
	typedef struct packed {
		logic [2:0]   cmd;
		logic         lt;
		logic         eq;
		logic         gt;
		logic         neg;
		logic         dz;
		logic [W-1:0] alu_res;
		logic         alu_ovf;
		logic [W-1:0] mul_mag;
		logic         mul_hi;
		logic         div_hi;
	} side_t;

endpackage

>>> rtl/fpa_prep.sv
// Front stages: simple ops and flags, magnitudes, multiplier, division setup.
module fpa_prep (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic [2:0]               command,
	input  logic signed [fpa_pkg::W-1:0] operand_a,
	input  logic signed [fpa_pkg::W-1:0] operand_b,
	output logic                     out_valid,
	output fpa_pkg::side_t           out_side,
	output logic [fpa_pkg::W-1:0]    out_rem,
	output logic [fpa_pkg::W-1:0]    out_nq,
	output logic [fpa_pkg::W:0]      out_den
);

	logic                     lt, eq, gt, dz;
	logic [fpa_pkg::W:0]      sum_w, diff_w;
	logic [fpa_pkg::W-1:0]    mag_a, mag_b, alu_res;
	logic                     alu_ovf;
	fpa_pkg::side_t           side_new;
	fpa_pkg::side_t           side_mid;

	logic                     valid_s1, valid_s2, valid_s3;
	fpa_pkg::side_t           side_s1, side_s2, side_s3;
	logic [fpa_pkg::W-1:0]    mag_a_s1, mag_b_s1;
	logic [2*fpa_pkg::W-1:0]  prod_s2, num_s2;
	logic [fpa_pkg::W:0]      den_s2, den_s3;
	logic [fpa_pkg::W-1:0]    rem_s3, nq_s3;
	logic [2*fpa_pkg::W-1:0]  rsum;

	// Compare, add/sub with one guard bit, magnitudes
	always_comb begin
		lt     = operand_a < operand_b;
		eq     = operand_a == operand_b;
		gt     = operand_a > operand_b;
		sum_w  = {operand_a[fpa_pkg::W-1], operand_a} + {operand_b[fpa_pkg::W-1], operand_b};
		diff_w = {operand_a[fpa_pkg::W-1], operand_a} - {operand_b[fpa_pkg::W-1], operand_b};
		mag_a  = operand_a[fpa_pkg::W-1] ? (~operand_a + 1'b1) : operand_a;
		mag_b  = operand_b[fpa_pkg::W-1] ? (~operand_b + 1'b1) : operand_b;
		dz     = (command == fpa_pkg::CMD_DIV) && (operand_b == '0);
	end

	// Simple-command results; x/0 is 0 for a zero dividend, else saturates by sign
	always_comb begin
		alu_res = '0;
		alu_ovf = 1'b0;
		case (command)
			fpa_pkg::CMD_ADD: begin
				alu_ovf = sum_w[fpa_pkg::W] != sum_w[fpa_pkg::W-1];
				alu_res = alu_ovf ? (sum_w[fpa_pkg::W] ? fpa_pkg::WORD_MIN : fpa_pkg::WORD_MAX)
					: sum_w[fpa_pkg::W-1:0];
			end
			fpa_pkg::CMD_SUB: begin
				alu_ovf = diff_w[fpa_pkg::W] != diff_w[fpa_pkg::W-1];
				alu_res = alu_ovf ? (diff_w[fpa_pkg::W] ? fpa_pkg::WORD_MIN : fpa_pkg::WORD_MAX)
					: diff_w[fpa_pkg::W-1:0];
			end
			fpa_pkg::CMD_DIV: begin
				if (operand_a == '0)
					alu_res = '0;
				else
					alu_res = operand_a[fpa_pkg::W-1] ? fpa_pkg::WORD_MIN : fpa_pkg::WORD_MAX;
			end
			fpa_pkg::CMD_MIN: alu_res = lt ? operand_a : operand_b;
			fpa_pkg::CMD_MAX: alu_res = gt ? operand_a : operand_b;
			fpa_pkg::CMD_INC: begin
				alu_ovf = operand_a == fpa_pkg::WORD_MAX;
				alu_res = alu_ovf ? fpa_pkg::WORD_MAX : operand_a + 1'b1;
			end
			default: alu_res = '0;
		endcase
	end

	always_comb begin
		side_new         = '0;
		side_new.cmd     = command;
		side_new.lt      = lt;
		side_new.eq      = eq;
		side_new.gt      = gt;
		side_new.neg     = operand_a[fpa_pkg::W-1] ^ operand_b[fpa_pkg::W-1];
		side_new.dz      = dz;
		side_new.alu_res = alu_res;
		side_new.alu_ovf = alu_ovf;
	end

	// Round-half-up on the product magnitude: ties away from zero once sign applied
	assign rsum = prod_s2 + ((2*fpa_pkg::W)'(1) << (fpa_pkg::FRAC_BITS - 1));

	// s3 side info: scaled product and quotient range check
	always_comb begin
		side_mid         = side_s2;
		side_mid.mul_mag = rsum[fpa_pkg::FRAC_BITS+fpa_pkg::W-1:fpa_pkg::FRAC_BITS];
		side_mid.mul_hi  = |rsum[2*fpa_pkg::W-1:fpa_pkg::FRAC_BITS+fpa_pkg::W];
		side_mid.div_hi  = {1'b0, num_s2[2*fpa_pkg::W-1:fpa_pkg::W]} >= den_s2;
	end

	// Valid pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Data pipe
	always_ff @(posedge clk) begin
		// s1: operands in magnitude form
		side_s1  <= side_new;
		mag_a_s1 <= mag_a;
		mag_b_s1 <= mag_b;
		// s2: product, dividend 2*(|a|<<F)+|b| and divisor 2*|b|
		side_s2  <= side_s1;
		prod_s2  <= mag_a_s1 * mag_b_s1;
		num_s2   <= ({{fpa_pkg::W{1'b0}}, mag_a_s1} << (fpa_pkg::FRAC_BITS + 1))
			+ {{fpa_pkg::W{1'b0}}, mag_b_s1};
		den_s2   <= {mag_b_s1, 1'b0};
		// s3: scaled product, quotient range check, divider seed
		side_s3  <= side_mid;
		rem_s3   <= num_s2[2*fpa_pkg::W-1:fpa_pkg::W];
		nq_s3    <= num_s2[fpa_pkg::W-1:0];
		den_s3   <= den_s2;
	end

	assign out_valid = valid_s3;
	assign out_side  = side_s3;
	assign out_rem   = rem_s3;
	assign out_nq    = nq_s3;
	assign out_den   = den_s3;

endmodule

>>> rtl/fpa_div_cell.sv
// One restoring-division cell: produces one quotient bit and passes the word on.
module fpa_div_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  fpa_pkg::side_t        in_side,
	input  logic [fpa_pkg::W-1:0] in_rem,
	input  logic [fpa_pkg::W-1:0] in_nq,
	input  logic [fpa_pkg::W:0]   in_den,
	output logic                  out_valid,
	output fpa_pkg::side_t        out_side,
	output logic [fpa_pkg::W-1:0] out_rem,
	output logic [fpa_pkg::W-1:0] out_nq,
	output logic [fpa_pkg::W:0]   out_den
);

	logic [fpa_pkg::W:0] trial;
	logic                ge;
	logic [fpa_pkg::W:0] diff;

	logic                  valid_q;
	fpa_pkg::side_t        side_q;
	logic [fpa_pkg::W-1:0] rem_q, nq_q;
	logic [fpa_pkg::W:0]   den_q;

	// Shift next dividend bit into the partial remainder, subtract if it fits
	always_comb begin
		trial = {in_rem, in_nq[fpa_pkg::W-1]};
		ge    = trial >= in_den;
		diff  = ge ? trial - in_den : trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else
			valid_q <= in_valid;
	end

	// Remainder stays below the divisor, so it fits in W bits
	always_ff @(posedge clk) begin
		side_q <= in_side;
		rem_q  <= diff[fpa_pkg::W-1:0];
		nq_q   <= {in_nq[fpa_pkg::W-2:0], ge};
		den_q  <= in_den;
	end

	assign out_valid = valid_q;
	assign out_side  = side_q;
	assign out_rem   = rem_q;
	assign out_nq    = nq_q;
	assign out_den   = den_q;

endmodule

>>> rtl/fixed_point_alu_q24_8_core.sv
// Pipeline: done pulses once a started word has passed 3 front stages, 32 divider cells and
// 1 output stage; the row of divider cells resolves one quotient bit per cell.
// Throughput: one word per cycle for every command; busy stays low.
// The receiver cannot stall: each result is on the ports for the single cycle that done is high.
// Reset: arst_n clears all valid bits at once; words in flight are dropped, no result follows.
// Top level: front stages, chain of divider cells and the output stage.
module fixed_point_alu_q24_8_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [2:0]                   command,
	input  logic signed [fpa_pkg::W-1:0] operand_a,
	input  logic signed [fpa_pkg::W-1:0] operand_b,
	output logic                         done,
	output logic signed [fpa_pkg::W-1:0] result,
	output logic                         a_less_b,
	output logic                         a_equal_b,
	output logic                         a_greater_b,
	output logic                         overflow,
	output logic                         divide_by_zero
);

	logic                  valid_c [fpa_pkg::W+1];
	fpa_pkg::side_t        side_c  [fpa_pkg::W+1];
	logic [fpa_pkg::W-1:0] rem_c   [fpa_pkg::W+1];
	logic [fpa_pkg::W-1:0] nq_c    [fpa_pkg::W+1];
	logic [fpa_pkg::W:0]   den_c   [fpa_pkg::W+1];

	fpa_pkg::side_t        side_l;
	logic [fpa_pkg::W-1:0] md_mag, md_res, fin_res;
	logic                  md_hi, md_ovf, use_md, fin_ovf;

	logic                  done_q;
	logic [fpa_pkg::W-1:0] result_q;
	logic                  lt_q, eq_q, gt_q, ovf_q, dz_q;

	assign busy = 1'b0;

	fpa_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (start && !busy),
		.command   (command),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.out_valid (valid_c[0]),
		.out_side  (side_c[0]),
		.out_rem   (rem_c[0]),
		.out_nq    (nq_c[0]),
		.out_den   (den_c[0])
	);

	// One cell per quotient bit, most significant first
	for (genvar i = 0; i < fpa_pkg::W; i++) begin : g_cell
		fpa_div_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_valid  (valid_c[i]),
			.in_side   (side_c[i]),
			.in_rem    (rem_c[i]),
			.in_nq     (nq_c[i]),
			.in_den    (den_c[i]),
			.out_valid (valid_c[i+1]),
			.out_side  (side_c[i+1]),
			.out_rem   (rem_c[i+1]),
			.out_nq    (nq_c[i+1]),
			.out_den   (den_c[i+1])
		);
	end

	assign side_l = side_c[fpa_pkg::W];

	// Sign and saturate the multiply or divide magnitude, then pick the result
	always_comb begin
		use_md = (side_l.cmd == fpa_pkg::CMD_MUL) || ((side_l.cmd == fpa_pkg::CMD_DIV) && !side_l.dz);
		md_mag = (side_l.cmd == fpa_pkg::CMD_MUL) ? side_l.mul_mag : nq_c[fpa_pkg::W];
		md_hi  = (side_l.cmd == fpa_pkg::CMD_MUL) ? side_l.mul_hi : side_l.div_hi;
		md_ovf = md_hi || (side_l.neg ? (md_mag > fpa_pkg::WORD_MIN) : md_mag[fpa_pkg::W-1]);
		if (md_ovf)
			md_res = side_l.neg ? fpa_pkg::WORD_MIN : fpa_pkg::WORD_MAX;
		else
			md_res = side_l.neg ? (~md_mag + 1'b1) : md_mag;
		fin_res = use_md ? md_res : side_l.alu_res;
		fin_ovf = use_md ? md_ovf : side_l.alu_ovf;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			done_q <= 1'b0;
		else
			done_q <= valid_c[fpa_pkg::W];
	end

	always_ff @(posedge clk) begin
		result_q <= fin_res;
		lt_q     <= side_l.lt;
		eq_q     <= side_l.eq;
		gt_q     <= side_l.gt;
		ovf_q    <= fin_ovf;
		dz_q     <= side_l.dz;
	end

	assign done           = done_q;
	assign result         = result_q;
	assign a_less_b       = lt_q;
	assign a_equal_b      = eq_q;
	assign a_greater_b    = gt_q;
	assign overflow       = ovf_q;
	assign divide_by_zero = dz_q;

endmodule

>>> rtl/fpa_checker.sv
// Port-level checks on the fixed-point ALU, bound to the top level.
module fpa_checker (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic                         done,
	input  logic signed [fpa_pkg::W-1:0] result,
	input  logic                         a_less_b,
	input  logic                         a_equal_b,
	input  logic                         a_greater_b,
	input  logic                         overflow,
	input  logic                         divide_by_zero
);

	// A result word needs a start exactly one latency earlier
	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, fpa_pkg::LATENCY))
		else $error("done without matching start");

	// Exactly one compare flag per word
	a_cmp_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $onehot({a_less_b, a_equal_b, a_greater_b}))
		else $error("compare flags not one-hot");

	// Saturated words sit on a rail
	a_ovf_rail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && overflow) |-> (result == fpa_pkg::WORD_MAX || result == fpa_pkg::WORD_MIN))
		else $error("overflow flagged on a non-saturated result");

	// Divide by zero never also reports overflow
	a_dz_no_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		(done && divide_by_zero) |-> !overflow)
		else $error("divide by zero with overflow");

endmodule

bind fixed_point_alu_q24_8_core fpa_checker u_fpa_checker (.*);
